### rtl/assert_macros.svh
// Assertion macros for the allocator RTL.
// Included by files that carry concurrent checks; depends on clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/ffba_pkg.sv
// Shared types and codes for the first-fit block allocator.
// No dependencies; imported by ffba_alu and first_fit_block_allocator.
package ffba_pkg;

  localparam int unsigned FIELD_W = 17;
  localparam int unsigned SLACK_W = 11;
  localparam logic [SLACK_W-1:0] SLACK_RESET = 11'd32;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_ALLOC   = 2'd0,
    STAT_NOFIT   = 2'd1,
    STAT_FREED   = 2'd2,
    STAT_IGNORED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_SH_RD,
    S_SH_WR,
    S_WR_NEW,
    S_WR_HIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic hit;
    logic split;
  } alu_flags_t;

endpackage

### rtl/ffba_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module ffba_ram #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ffba_alu.sv
// Shared entry evaluator: fit, split and offset-match tests plus the split arithmetic.
// Depends on ffba_pkg.
module ffba_alu import ffba_pkg::*; #(
  parameter int unsigned AW           = 17,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic [AW-1:0]      start_i,
  input  logic [AW-1:0]      size_i,
  input  logic               free_i,
  input  logic               op_i,
  input  logic [FIELD_W-1:0] req_i,
  input  logic [FIELD_W-1:0] off_i,
  input  logic [SLACK_W-1:0] slack_i,
  input  logic               full_i,
  output alu_flags_t         flags_o,
  output logic [FIELD_W-1:0] payload_o,
  output logic [AW-1:0]      new_start_o,
  output logic [AW-1:0]      new_size_o,
  output logic [AW-1:0]      kept_size_o
);

  localparam int unsigned CW = ((AW > 18) ? AW : 18) + 1;
  localparam logic [CW-1:0] HDR = CW'(HEADER_BYTES);

  logic [CW-1:0] start_e, size_e, req_e, off_e, slack_e;
  logic [CW-1:0] pay, need, nstart, nsize;
  logic          fit, match, split;

  always_comb begin
    start_e = CW'(start_i);
    size_e  = CW'(size_i);
    req_e   = CW'(req_i);
    off_e   = CW'(off_i);
    slack_e = CW'(slack_i);
    pay     = start_e + HDR;
    need    = req_e + HDR + slack_e;
    nstart  = pay + req_e;
    nsize   = size_e - req_e - HDR;
    fit     = free_i && (size_e >= req_e);
    split   = fit && (size_e > need) && !full_i;
    match   = (off_i != '0) && (pay == off_e);
  end

  assign flags_o.hit   = (op_i == OP_ALLOC) ? fit : match;
  assign flags_o.split = (op_i == OP_ALLOC) && split;
  assign payload_o     = pay[FIELD_W-1:0];
  assign new_start_o   = nstart[AW-1:0];
  assign new_size_o    = nsize[AW-1:0];
  // a free request keeps the entry size as it is
  assign kept_size_o   = flags_o.split ? req_e[AW-1:0] : size_i;

endmodule

### rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: sequencer, block table RAM, output register.
// Depends on ffba_pkg, ffba_ram, ffba_alu and assert_macros.svh.
//
//  channel  | direction | tdata (low bit up)                 | tuser
//  s_axis   | in        | req_size[16:0], free_offset[33:17] | op
//  m_axis   | out       | payload_offset[16:0]               | status[1:0]
//  cfg      | in        | min_split_slack[10:0]              | -
//
// Per entry scanned an item reads (S_RD), then checks in the shared evaluator (S_CHK).
// A split hit moves later entries up (S_SH_RD, S_SH_WR) and writes the new block
// (S_WR_NEW); a hit writes its entry (S_WR_HIT); S_DONE loads the result; S_IDLE takes the
// next item. Worst: full table, no fit or last-entry hit. A null free skips to S_DONE.
// s_axis_tready is high only when idle; a held output register stalls the load cycle.
// Reset leaves one free block covering the heap; no clearing pass is needed.
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned HEADER_BYTES = 24,
  parameter int unsigned MAX_BLOCKS   = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [39:0]        s_axis_tdata,  // req_size[16:0], free_offset[33:17], zero pad
  input  logic               s_axis_tuser,  // op
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,  // payload_offset[16:0], zero pad
  output logic [1:0]         m_axis_tuser,  // status
  input  logic               cfg_we_i,
  input  logic [SLACK_W-1:0] cfg_wdata_i
);

  `include "assert_macros.svh"

  localparam int unsigned AW   = $clog2(HEAP_BYTES + 1);
  localparam int unsigned IW   = $clog2(MAX_BLOCKS);
  localparam int unsigned CNTW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned EW   = 2 * AW + 1;
  localparam logic [AW-1:0]   RST_SIZE = AW'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [CNTW-1:0] MAX_CNT  = CNTW'(MAX_BLOCKS);
  localparam logic [CNTW-1:0] ONE      = CNTW'(1);

  state_e             state_q, state_d;
  logic               op_q, op_d;
  logic [FIELD_W-1:0] req_q, req_d, off_q, off_d;
  logic [CNTW-1:0]    idx_q, idx_d, j_q, j_d, cnt_q, cnt_d;
  logic [SLACK_W-1:0] slack_q;
  logic [AW-1:0]      hit_start_q, hit_start_d, kept_q, kept_d;
  logic [AW-1:0]      nstart_q, nstart_d, nsize_q, nsize_d;
  status_e            res_stat_q, res_stat_d;
  logic [FIELD_W-1:0] res_off_q, res_off_d;
  logic               e0_wr_q, e0_wr_d;
  logic               rd_zero_q, rd_zero_d;
  logic               out_vld_q, out_vld_d;
  status_e            out_stat_q, out_stat_d;
  logic [FIELD_W-1:0] out_off_q, out_off_d;

  logic               ram_we, ram_re;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  logic [EW-1:0]      ram_wdata, ram_rdata, ent;
  logic               s_acc;
  logic               done_go;

  alu_flags_t         flags;
  logic [FIELD_W-1:0] alu_pay;
  logic [AW-1:0]      alu_nstart, alu_nsize, alu_kept;

  ffba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // entry 0 reads as the reset block until first written
  assign ent = (rd_zero_q && !e0_wr_q) ? {1'b1, RST_SIZE, {AW{1'b0}}} : ram_rdata;

  ffba_alu #(.AW(AW), .HEADER_BYTES(HEADER_BYTES)) u_alu (
    .start_i     (ent[AW-1:0]),
    .size_i      (ent[2*AW-1:AW]),
    .free_i      (ent[EW-1]),
    .op_i        (op_q),
    .req_i       (req_q),
    .off_i       (off_q),
    .slack_i     (slack_q),
    .full_i      (cnt_q == MAX_CNT),
    .flags_o     (flags),
    .payload_o   (alu_pay),
    .new_start_o (alu_nstart),
    .new_size_o  (alu_nsize),
    .kept_size_o (alu_kept)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign done_go       = (state_q == S_DONE) && (!out_vld_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    req_d       = req_q;
    off_d       = off_q;
    idx_d       = idx_q;
    j_d         = j_q;
    cnt_d       = cnt_q;
    hit_start_d = hit_start_q;
    kept_d      = kept_q;
    nstart_d    = nstart_q;
    nsize_d     = nsize_q;
    res_stat_d  = res_stat_q;
    res_off_d   = res_off_q;
    e0_wr_d     = e0_wr_q;
    rd_zero_d   = rd_zero_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_stat_d  = out_stat_q;
    out_off_d   = out_off_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[IW-1:0];
    ram_wdata   = {op_q, kept_q, hit_start_q};
    ram_re      = 1'b0;
    ram_raddr   = idx_q[IW-1:0];

    case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          op_d  = s_axis_tuser;
          req_d = s_axis_tdata[FIELD_W-1:0];
          off_d = s_axis_tdata[2*FIELD_W-1:FIELD_W];
          idx_d = '0;
          if (s_axis_tuser == OP_FREE && s_axis_tdata[2*FIELD_W-1:FIELD_W] == '0) begin
            res_stat_d = STAT_IGNORED;
            res_off_d  = '0;
            state_d    = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (idx_q == cnt_q) begin
          res_stat_d = (op_q == OP_ALLOC) ? STAT_NOFIT : STAT_IGNORED;
          res_off_d  = '0;
          state_d    = S_DONE;
        end else begin
          ram_re    = 1'b1;
          rd_zero_d = (idx_q == '0);
          state_d   = S_CHK;
        end
      end
      S_CHK: begin
        if (flags.hit) begin
          hit_start_d = ent[AW-1:0];
          kept_d      = alu_kept;
          nstart_d    = alu_nstart;
          nsize_d     = alu_nsize;
          j_d         = cnt_q;
          if (op_q == OP_ALLOC) begin
            res_stat_d = STAT_ALLOC;
            res_off_d  = alu_pay;
          end else begin
            res_stat_d = STAT_FREED;
            res_off_d  = '0;
          end
          if (!flags.split) begin
            state_d = S_WR_HIT;
          end else if (cnt_q > idx_q + ONE) begin
            state_d = S_SH_RD;
          end else begin
            state_d = S_WR_NEW;
          end
        end else begin
          idx_d   = idx_q + ONE;
          state_d = S_RD;
        end
      end
      S_SH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = IW'(j_q - ONE);
        rd_zero_d = 1'b0;
        state_d   = S_SH_WR;
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[IW-1:0];
        ram_wdata = ent;
        j_d       = j_q - ONE;
        state_d   = (j_q - ONE > idx_q + ONE) ? S_SH_RD : S_WR_NEW;
      end
      S_WR_NEW: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(idx_q + ONE);
        ram_wdata = {1'b1, nsize_q, nstart_q};
        cnt_d     = cnt_q + ONE;
        state_d   = S_WR_HIT;
      end
      S_WR_HIT: begin
        // free marks the entry free, alloc marks it used
        ram_we = 1'b1;
        if (idx_q == '0) begin
          e0_wr_d = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_stat_d = res_stat_q;
          out_off_d  = res_off_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= ONE;
      slack_q   <= SLACK_RESET;
      e0_wr_q   <= 1'b0;
      rd_zero_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      e0_wr_q   <= e0_wr_d;
      rd_zero_q <= rd_zero_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        slack_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    req_q       <= req_d;
    off_q       <= off_d;
    idx_q       <= idx_d;
    j_q         <= j_d;
    hit_start_q <= hit_start_d;
    kept_q      <= kept_d;
    nstart_q    <= nstart_d;
    nsize_q     <= nsize_d;
    res_stat_q  <= res_stat_d;
    res_off_q   <= res_off_d;
    out_stat_q  <= out_stat_d;
    out_off_q   <= out_off_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(24 - FIELD_W){1'b0}}, out_off_q};
  assign m_axis_tuser  = out_stat_q;

  `ASSERT_RST(a_cnt_range, (cnt_q != '0) && (cnt_q <= MAX_CNT), "block count out of range")
  `ASSERT_RST(a_cnt_step, $changed(cnt_q) |-> (cnt_q == $past(cnt_q) + ONE), "block count jumped")
  `ASSERT_RST(a_done_load, done_go |=> out_vld_q && (state_q == S_IDLE), "result not loaded")
  `ASSERT_RST(a_acc_busy, s_acc |=> !s_axis_tready, "ready while an item is in work")

endmodule
